// ----- rtl/nps_pkg.sv -----
// Package for the 3D nearest point search block.
// Holds field widths, request kind codes and the sequencer state type.
// No dependencies.
`default_nettype none

package nps_pkg;

  localparam int unsigned COORD_W    = 18;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned DIST_W     = 38;
  localparam int unsigned ABS_W      = COORD_W + 1;
  localparam int unsigned SQ_W       = 2 * COORD_W + 1;
  localparam int unsigned POINT_W    = 3 * COORD_W;
  localparam int unsigned MAX_POINTS = 65536;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/nps_req_if.sv -----
// Request channel of the nearest point search block: kind and query/load point.
// Depends on nps_pkg for the field widths.
`default_nettype none

interface nps_req_if
  import nps_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [KIND_W-1:0]   kind;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;

  modport source (output valid, kind, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/nps_rsp_if.sv -----
// Response channel of the nearest point search block: index, distance, empty flag.
// Depends on nps_pkg for the field widths.
`default_nettype none

interface nps_rsp_if
  import nps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  nearest_index;
  logic [DIST_W-1:0]   nearest_distance;
  logic                store_empty;

  modport source (output valid, nearest_index, nearest_distance, store_empty, input ready);
  modport sink   (input valid, nearest_index, nearest_distance, store_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/nearest_point_search_3d.sv -----
// Brute-force 3D nearest point search over a point memory of MaxPoints entries.
// Clear and load requests complete on acceptance. A query reads the N stored
// points through the single read port of the point memory into a difference,
// square, sum and compare pipeline (straight to the response on an empty store).
// The next request is taken the cycle after the response loads. Reset clears the
// point count and control state; the point memory is only read below the count.
`default_nettype none

module nearest_point_search_3d
  import nps_pkg::*;
#(
  parameter int unsigned MaxPoints = MAX_POINTS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nps_req_if.sink    req_i,
  nps_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  // Point memory and count.
  logic [POINT_W-1:0] mem [MaxPoints];
  logic [CntW-1:0]    count_q;
  logic [POINT_W-1:0] rd_data_q;

  state_e state_q, state_d;

  logic                      in_ready;
  logic                      req_acc;
  logic                      rd_en;
  logic                      issue_last;
  logic                      rsp_load;
  logic [CntW-1:0]           issue_q;
  logic signed [COORD_W-1:0] qx_q, qy_q, qz_q;

  // Pipeline tags.
  logic            v1_q, v2_q, v3_q, v4_q;
  logic            l1_q, l2_q, l3_q, l4_q;
  logic [IdxW-1:0] i1_q, i2_q, i3_q, i4_q;

  logic [ABS_W-1:0]  abs_d [3];
  logic [ABS_W-1:0]  abs_q [3];
  logic [2*ABS_W-1:0] prod [3];
  logic [SQ_W-1:0]   sq_q  [3];
  logic [DIST_W-1:0] sum_q;

  logic [DIST_W-1:0] best_dist_q;
  logic [IdxW-1:0]   best_idx_q;
  logic              empty_q;

  logic                rsp_valid_q;
  logic [INDEX_W-1:0]  rsp_index_q;
  logic [DIST_W-1:0]   rsp_dist_q;
  logic                rsp_empty_q;

  assign req_acc    = req_i.valid && in_ready;
  assign issue_last = (issue_q == count_q - CntW'(1));
  assign req_i.ready = in_ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc && req_i.kind == KIND_QUERY) begin
          state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (v4_q && l4_q) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rsp_load = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   rd_en    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: rsp_load = !rsp_valid_q || rsp_o.ready;
      default:   ;
    endcase
  end

  // Memory: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.kind == KIND_LOAD && count_q < CntW'(MaxPoints)) begin
      mem[count_q[IdxW-1:0]] <= {req_i.coord_z, req_i.coord_y, req_i.coord_x};
    end
    if (rd_en) begin
      rd_data_q <= mem[issue_q[IdxW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_acc) begin
        priority case (req_i.kind)
          KIND_CLEAR: count_q <= '0;
          KIND_LOAD: begin
            if (count_q < CntW'(MaxPoints)) count_q <= count_q + CntW'(1);
          end
          KIND_QUERY: issue_q <= '0;
          default: ;
        endcase
      end else if (rd_en) begin
        issue_q <= issue_q + CntW'(1);
      end
      v1_q <= rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Absolute coordinate differences against the query point.
  always_comb begin
    logic signed [ABS_W-1:0] d [3];
    d[0] = ABS_W'(qx_q) - ABS_W'($signed(rd_data_q[COORD_W-1:0]));
    d[1] = ABS_W'(qy_q) - ABS_W'($signed(rd_data_q[2*COORD_W-1:COORD_W]));
    d[2] = ABS_W'(qz_q) - ABS_W'($signed(rd_data_q[3*COORD_W-1:2*COORD_W]));
    for (int k = 0; k < 3; k++) begin
      abs_d[k] = d[k][ABS_W-1] ? ABS_W'(-d[k]) : ABS_W'(d[k]);
      prod[k]  = {{ABS_W{1'b0}}, abs_q[k]} * {{ABS_W{1'b0}}, abs_q[k]};
    end
  end

  // Datapath registers: query latch, pipeline stages, running best, response.
  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.kind == KIND_QUERY) begin
      qx_q        <= req_i.coord_x;
      qy_q        <= req_i.coord_y;
      qz_q        <= req_i.coord_z;
      best_dist_q <= '0;
      best_idx_q  <= '0;
      empty_q     <= (count_q == '0);
    end
    i1_q <= issue_q[IdxW-1:0];
    l1_q <= issue_last;
    i2_q <= i1_q;
    l2_q <= l1_q;
    i3_q <= i2_q;
    l3_q <= l2_q;
    i4_q <= i3_q;
    l4_q <= l3_q;
    for (int k = 0; k < 3; k++) begin
      abs_q[k] <= abs_d[k];
      sq_q[k]  <= prod[k][SQ_W-1:0];
    end
    sum_q <= DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]);
    // The first point always takes the lead; later ones only when strictly closer.
    if (v4_q && (i4_q == '0 || sum_q < best_dist_q)) begin
      best_dist_q <= sum_q;
      best_idx_q  <= i4_q;
    end
    if (rsp_load) begin
      rsp_index_q <= INDEX_W'(best_idx_q);
      rsp_dist_q  <= best_dist_q;
      rsp_empty_q <= empty_q;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.nearest_index    = rsp_index_q;
  assign rsp_o.nearest_distance = rsp_dist_q;
  assign rsp_o.store_empty      = rsp_empty_q;

endmodule

`default_nettype wire
